### src/assert_macros.svh
// Assertion helpers for the RTL; the core file is the one that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/awmt_pkg.sv
package awmt_pkg;

    localparam int IN_W         = 13;
    localparam int MEAN_W       = 15;
    localparam int ROLL_W       = 9;
    localparam int PITCH_W      = 8;
    localparam int CORDIC_W     = 28;
    localparam int ANG_W        = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int OP_SHIFT     = 12;
    localparam int ROOT_W       = 25;
    localparam int RAD_W        = 2 * ROOT_W;
    localparam int SQ_W         = 26;

    localparam logic signed [ANG_W-1:0] ANG_HALF_PI      = 20'sd102944;
    localparam logic        [19:0]      DEG_PER_MRAD_Q24 = 20'd961264;

    localparam logic [1:0] UNIT_RAW     = 2'd0;
    localparam logic [1:0] UNIT_MILLI_G = 2'd1;
    localparam logic [1:0] UNIT_MPS2    = 2'd2;
    // The spare code gives raw counts like UNIT_RAW.
    localparam logic [1:0] UNIT_SPARE   = 2'd3;

    // Step angles atan(2^-i) in units of 2^-16 rad.
    function automatic logic [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
        logic [ANG_W-1:0] v;
        unique case (idx)
            4'd0:    v = 20'd51472;
            4'd1:    v = 20'd30386;
            4'd2:    v = 20'd16055;
            4'd3:    v = 20'd8150;
            4'd4:    v = 20'd4091;
            4'd5:    v = 20'd2047;
            4'd6:    v = 20'd1024;
            4'd7:    v = 20'd512;
            4'd8:    v = 20'd256;
            4'd9:    v = 20'd128;
            4'd10:   v = 20'd64;
            4'd11:   v = 20'd32;
            4'd12:   v = 20'd16;
            4'd13:   v = 20'd8;
            4'd14:   v = 20'd4;
            default: v = 20'd2;
        endcase
        return v;
    endfunction

endpackage

### src/awmt_div.sv
module awmt_div #(
    parameter int W = 18
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dvd,
    input  logic [W-1:0] i_dvs,
    output logic         o_busy,
    output logic [W-1:0] o_quo
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_dvd, r_dvs, r_quo;
    logic [W:0]       r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [W:0]       n_rem;
    logic [W:0]       n_diff;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    always_comb begin
        n_rem  = {r_rem[W-1:0], r_dvd[W-1]};
        n_diff = n_rem - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dvd;
            r_dvs <= i_dvs;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[W-2:0], 1'b0};
            if (!n_diff[W]) begin
                r_rem <= n_diff;
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

### src/awmt_sqrt.sv
module awmt_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [awmt_pkg::RAD_W-1:0]  i_rad,
    output logic                        o_busy,
    output logic [awmt_pkg::ROOT_W-1:0] o_root
);

    localparam int RW    = awmt_pkg::ROOT_W;
    localparam int REM_W = RW + 3;
    localparam int CNT_W = $clog2(RW + 1);

    logic [awmt_pkg::RAD_W-1:0] r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [RW-1:0]              r_root;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic [REM_W-1:0]           n_rem, n_trial;

    // Two radicand bits enter per cycle, one root bit leaves.
    always_comb begin
        n_rem   = {r_rem[REM_W-3:0], r_rad[awmt_pkg::RAD_W-1 -: 2]};
        n_trial = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(RW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[awmt_pkg::RAD_W-3:0], 2'b00};
            if (n_rem >= n_trial) begin
                r_rem  <= n_rem - n_trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= n_rem;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

### src/awmt_cordic.sv
module awmt_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [awmt_pkg::CORDIC_W-1:0] i_num,
    input  logic signed [awmt_pkg::CORDIC_W-1:0] i_den,
    output logic                                 o_busy,
    output logic signed [awmt_pkg::ANG_W-1:0]    o_ang
);

    localparam int CW = awmt_pkg::CORDIC_W;

    logic signed [CW-1:0]             r_x, r_y;
    logic signed [awmt_pkg::ANG_W-1:0] r_ang;
    logic [awmt_pkg::STEP_W-1:0]      r_i;
    logic                             r_busy, r_zero;
    logic signed [CW-1:0]             n_dx, n_dy;
    logic signed [awmt_pkg::ANG_W-1:0] n_step;

    always_comb begin
        n_dx   = r_y >>> r_i;
        n_dy   = r_x >>> r_i;
        n_step = $signed(awmt_pkg::atan_step(r_i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == awmt_pkg::STEP_W'(awmt_pkg::CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_num == '0) && (i_den == '0);
            // A vector in the left half plane is first turned by a quarter turn.
            if (i_den < 0) begin
                if (i_num >= 0) begin
                    r_x   <= i_num;
                    r_y   <= -i_den;
                    r_ang <= awmt_pkg::ANG_HALF_PI;
                end else begin
                    r_x   <= -i_num;
                    r_y   <= i_den;
                    r_ang <= -awmt_pkg::ANG_HALF_PI;
                end
            end else begin
                r_x   <= i_den;
                r_y   <= i_num;
                r_ang <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x   <= r_x + n_dx;
                r_y   <= r_y - n_dy;
                r_ang <= r_ang + n_step;
            end else begin
                r_x   <= r_x - n_dx;
                r_y   <= r_y + n_dy;
                r_ang <= r_ang - n_step;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_ang  = r_zero ? '0 : r_ang;

endmodule

### src/accel_window_mean_tilt_core.sv
// Sliding-window accelerometer mean with roll and pitch. Each accepted sample
// replaces the oldest entry of a WINDOW-deep window per axis and yields one
// result: the three rounded means in the unit chosen by the configuration
// register (raw counts, milli-g or m/s^2) and roll and pitch in whole degrees.
// One sample is processed at a time; the bit-serial mean divider, the
// bit-serial square root and the 16-step CORDIC pass for pitch run in turn,
// while the roll CORDIC pass runs under the square root. A result that is
// still waiting in the output register holds the block in its final state
// until it is taken. A finished result waits in the output register while
// the next sample is accepted. The window reads as zero after reset, with no
// clearing pass.
`include "assert_macros.svh"

module accel_window_mean_tilt_core #(
    parameter int WINDOW = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // sample_x, sample_y, sample_z, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // mean_out_x, mean_out_y, mean_out_z,
                                       // roll_degrees, pitch_degrees, zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    localparam int IW     = awmt_pkg::IN_W;
    localparam int MW     = awmt_pkg::MEAN_W;
    localparam int CW     = awmt_pkg::CORDIC_W;
    localparam int AW     = awmt_pkg::ANG_W;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SW     = IW + SLOT_W + 1;
    localparam int VW     = SW + 1;
    localparam int MAG_W  = 18;
    localparam int MR_W   = 12;
    localparam int DEG_W  = 8;
    localparam int C1_W   = IW + 10;
    localparam int C2_W   = C1_W - 8;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_SUM   = 10'b0000000100,
        S_PREP  = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_SQ    = 10'b0000100000,
        S_CV    = 10'b0001000000,
        S_SQRT  = 10'b0010000000,
        S_PITCH = 10'b0100000000,
        S_DEG   = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        D_MRAD = 2'b01,
        D_DEG  = 2'b10
    } t_deg_phase;

    t_state r_state, n_state;
    t_deg_phase r_dph;
    logic       r_deg_done;

    logic [1:0]                r_unit;
    logic [3*IW-1:0]           r_sample;
    logic [3*IW-1:0]           mem [WINDOW];
    logic [3*IW-1:0]           r_rd;
    logic [WINDOW-1:0]         r_valid;
    logic [SLOT_W-1:0]         r_slot;
    logic signed [SW-1:0]      r_sum [3];
    logic [2:0]                r_mneg;
    logic signed [IW-1:0]      r_mean [3];
    logic [IW-1:0]             r_mmag [3];
    logic [C1_W-1:0]           r_c1 [3];
    logic [C2_W-1:0]           r_c2 [3];
    logic [C2_W-1:0]           r_c3 [3];
    logic [awmt_pkg::SQ_W-1:0] r_py, r_pz;
    logic signed [AW-1:0]      r_roll_ang;
    logic [1:0]                r_aneg;
    logic [MR_W-1:0]           r_mr [2];
    logic [DEG_W-1:0]          r_dg [2];
    logic                      r_out_valid;
    logic [63:0]               r_out_data;

    logic                      in_fire, load_out;
    logic [SW-1:0]             div_dvd [3];
    logic [SW-1:0]             div_quo [3];
    logic [2:0]                div_neg;
    logic [2:0]                div_busy;
    logic                      sqrt_start, sqrt_busy;
    logic [awmt_pkg::ROOT_W-1:0] root;
    logic                      cor_start, cor_busy;
    logic signed [CW-1:0]      cor_num, cor_den;
    logic signed [AW-1:0]      cor_ang;
    logic [AW-1:0]             ang_mag [2];
    logic signed [MW-1:0]      out_mean [3];
    logic signed [awmt_pkg::ROLL_W-1:0]  out_roll;
    logic signed [awmt_pkg::PITCH_W-1:0] out_pitch;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= awmt_pkg::UNIT_RAW;
        end else if (i_cfg_valid) begin
            r_unit <= i_cfg_data;
        end
    end

    // Window store: one read and one write at the current slot.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            mem[r_slot] <= r_sample;
        end
        r_rd <= mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample <= s_axis_tdata[3*IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_slot  <= '0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
        end else if (r_state == S_SUM) begin
            r_valid[r_slot] <= 1'b1;
            r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
            for (int k = 0; k < 3; k++) begin
                // An entry never written counts as zero through its cleared valid bit.
                r_sum[k] <= r_sum[k]
                    + SW'($signed(r_sample[k*IW +: IW]))
                    - (r_valid[r_slot] ? SW'($signed(r_rd[k*IW +: IW])) : SW'(0));
            end
        end
    end

    // Rounded mean: t = trunc((2*sum + N) / 2), then trunc(t / N) in sign-magnitude.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [VW-1:0] v;
            logic [VW-1:0]        vm;
            v          = {r_sum[k], 1'b0} + VW'(WINDOW);
            div_neg[k] = v[VW-1];
            vm         = div_neg[k] ? VW'(-v) : VW'(v);
            div_dvd[k] = vm[VW-1:1];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        awmt_div #(.W(SW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_state == S_PREP),
            .i_dvd   (div_dvd[k]),
            .i_dvs   (SW'(WINDOW)),
            .o_busy  (div_busy[k]),
            .o_quo   (div_quo[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_mneg <= div_neg;
        end
        if (r_state == S_DIV && div_busy == 3'b000) begin
            for (int k = 0; k < 3; k++) begin
                r_mmag[k] <= div_quo[k][IW-1:0];
                r_mean[k] <= r_mneg[k] ? -$signed(div_quo[k][IW-1:0])
                                       : $signed(div_quo[k][IW-1:0]);
            end
        end
    end

    // Squares for the pitch magnitude and the unit scaling, one multiply per register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SQ) begin
            r_py <= awmt_pkg::SQ_W'(r_mean[1] * r_mean[1]);
            r_pz <= awmt_pkg::SQ_W'(r_mean[2] * r_mean[2]);
            for (int k = 0; k < 3; k++) begin
                r_c1[k] <= r_mmag[k] * ((r_unit == awmt_pkg::UNIT_MILLI_G) ? 10'd1000 : 10'd981);
            end
        end
        if (r_state == S_CV) begin
            for (int k = 0; k < 3; k++) begin
                r_c2[k] <= r_c1[k][C1_W-1:8];
            end
        end
        // Division by 100 as a reciprocal multiply; exact for these magnitudes.
        for (int k = 0; k < 3; k++) begin
            r_c3[k] <= C2_W'((34'(r_c2[k]) * 34'd5243) >> 19);
        end
    end

    assign sqrt_start = (r_state == S_CV);

    awmt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   ({r_py + r_pz, 24'd0}),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    // Roll runs while the root is formed; pitch follows on the same unit.
    always_comb begin
        cor_start = 1'b0;
        cor_num   = $signed({{(CW-IW-awmt_pkg::OP_SHIFT){r_mean[1][IW-1]}}, r_mean[1],
                             {awmt_pkg::OP_SHIFT{1'b0}}});
        cor_den   = $signed({{(CW-IW-awmt_pkg::OP_SHIFT){r_mean[2][IW-1]}}, r_mean[2],
                             {awmt_pkg::OP_SHIFT{1'b0}}});
        if (r_state == S_SQ) begin
            cor_start = 1'b1;
        end else if (r_state == S_SQRT) begin
            cor_start = !sqrt_busy && !cor_busy;
            cor_num   = -$signed({{(CW-IW-awmt_pkg::OP_SHIFT){r_mean[0][IW-1]}}, r_mean[0],
                                  {awmt_pkg::OP_SHIFT{1'b0}}});
            cor_den   = $signed(CW'(root));
        end
    end

    awmt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_num   (cor_num),
        .i_den   (cor_den),
        .o_busy  (cor_busy),
        .o_ang   (cor_ang)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_SQRT && cor_start) begin
            r_roll_ang <= cor_ang;
        end
    end

    always_comb begin
        ang_mag[0] = (r_roll_ang < 0) ? AW'(-r_roll_ang) : AW'(r_roll_ang);
        ang_mag[1] = (cor_ang < 0) ? AW'(-cor_ang) : AW'(cor_ang);
    end

    // Angle to milliradians, then milliradians to degrees.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dph      <= D_MRAD;
            r_deg_done <= 1'b0;
        end else if (r_state == S_DEG) begin
            unique case (r_dph)
                D_MRAD: begin
                    r_dph      <= D_DEG;
                    r_deg_done <= 1'b0;
                end
                D_DEG: begin
                    r_deg_done <= 1'b1;
                end
                default: begin
                    r_dph <= D_MRAD;
                end
            endcase
        end else begin
            r_dph      <= D_MRAD;
            r_deg_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DEG && r_dph == D_MRAD) begin
            r_aneg[0] <= r_roll_ang < 0;
            r_aneg[1] <= cor_ang < 0;
            for (int k = 0; k < 2; k++) begin
                r_mr[k] <= MR_W'((28'(ang_mag[k][MAG_W-1:0]) * 28'd1000) >> 16);
            end
        end
        if (r_state == S_DEG && r_dph == D_DEG) begin
            for (int k = 0; k < 2; k++) begin
                r_dg[k] <= DEG_W'((32'(r_mr[k]) * 32'(awmt_pkg::DEG_PER_MRAD_Q24)) >> 24);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            unique case (r_unit)
                awmt_pkg::UNIT_MILLI_G:
                    out_mean[k] = r_mneg[k] ? -$signed(MW'(r_c2[k])) : $signed(MW'(r_c2[k]));
                awmt_pkg::UNIT_MPS2:
                    out_mean[k] = r_mneg[k] ? -$signed(MW'(r_c3[k])) : $signed(MW'(r_c3[k]));
                default:
                    out_mean[k] = MW'(r_mean[k]);
            endcase
        end
        out_roll  = r_aneg[0] ? -$signed(awmt_pkg::ROLL_W'(r_dg[0]))
                              : $signed(awmt_pkg::ROLL_W'(r_dg[0]));
        out_pitch = r_aneg[1] ? -$signed(awmt_pkg::PITCH_W'(r_dg[1]))
                              : $signed(awmt_pkg::PITCH_W'(r_dg[1]));
    end

    assign load_out = (r_state == S_DEG) && r_deg_done && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = S_READ;
            S_READ:  n_state = S_SUM;
            S_SUM:   n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (div_busy == 3'b000) n_state = S_SQ;
            S_SQ:    n_state = S_CV;
            S_CV:    n_state = S_SQRT;
            S_SQRT:  if (cor_start) n_state = S_PITCH;
            S_PITCH: if (!cor_busy) n_state = S_DEG;
            S_DEG:   if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {2'b00, out_pitch, out_roll, out_mean[2], out_mean[1], out_mean[0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `ASSERT_ALWAYS(a_slot_range, r_slot <= SLOT_W'(WINDOW - 1), "write slot out of range")
    `ASSERT_IMPLIES(a_load_from_deg, $rose(r_out_valid), $past(r_state == S_DEG),
        "result loaded outside the final state")
    `ASSERT_IMPLIES(a_roll_range, r_out_valid,
        ($signed(r_out_data[53:45]) <= 180) && ($signed(r_out_data[53:45]) >= -180),
        "roll out of range")
    `ASSERT_IMPLIES(a_pitch_range, r_out_valid,
        ($signed(r_out_data[61:54]) <= 90) && ($signed(r_out_data[61:54]) >= -90),
        "pitch out of range")

endmodule

### tb/tb_accel_window_mean_tilt_checker.sv
`timescale 1ns / 1ps

module tb_accel_window_mean_tilt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int DEPTH = 10;

    typedef struct packed {
        logic signed [awmt_pkg::PITCH_W-1:0] pitch;
        logic signed [awmt_pkg::ROLL_W-1:0]  roll;
        logic signed [awmt_pkg::MEAN_W-1:0]  mz;
        logic signed [awmt_pkg::MEAN_W-1:0]  my;
        logic signed [awmt_pkg::MEAN_W-1:0]  mx;
    } t_tilt_result;

    longint hist_x[DEPTH];
    longint hist_y[DEPTH];
    longint hist_z[DEPTH];
    longint sum_x, sum_y, sum_z;
    int     slot;
    logic [1:0] unit_sel;
    t_tilt_result tilt_queue[$];

    longint step_angle[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};

    // Shift right rounding toward minus infinity.
    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint int_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint num, longint den);
        longint x, y, ang, nx, dx, dy;
        x = den;
        y = num;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; y = -x; x = nx; ang = 102944;
            end else begin
                nx = -y; y = x; x = nx; ang = -102944;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
                x += dx; y -= dy; ang += step_angle[i];
            end else begin
                x -= dx; y += dy; ang -= step_angle[i];
            end
        end
        return ang;
    endfunction

    function automatic longint to_degrees(longint ang);
        longint mag, mrad, deg;
        mag = (ang < 0) ? -ang : ang;
        mrad = mag * 1000 / 65536;
        deg = (mrad * 961264) >>> 24;
        return (ang < 0) ? -deg : deg;
    endfunction

    function automatic longint rounded_mean(longint s);
        longint t;
        t = (2 * s + DEPTH) / 2;
        return t / DEPTH;
    endfunction

    function automatic longint in_units(longint m);
        if (unit_sel == awmt_pkg::UNIT_MILLI_G) return (m * 1000) / 256;
        if (unit_sel == awmt_pkg::UNIT_MPS2) return (m * 981) / 25600;
        return m;
    endfunction

    task automatic predict_tilt(logic [39:0] d);
        longint sx, sy, sz, mx, my, mz, root, roll_ang, pitch_ang;
        t_tilt_result r;
        sx = longint'($signed(d[12:0]));
        sy = longint'($signed(d[25:13]));
        sz = longint'($signed(d[38:26]));
        sum_x += sx - hist_x[slot];
        sum_y += sy - hist_y[slot];
        sum_z += sz - hist_z[slot];
        hist_x[slot] = sx;
        hist_y[slot] = sy;
        hist_z[slot] = sz;
        slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
        mx = rounded_mean(sum_x);
        my = rounded_mean(sum_y);
        mz = rounded_mean(sum_z);
        roll_ang = vector_angle(my * 4096, mz * 4096);
        root = int_root(longint'(my * my + mz * mz) << 24);
        pitch_ang = vector_angle(-mx * 4096, root);
        r.mx = awmt_pkg::MEAN_W'(in_units(mx));
        r.my = awmt_pkg::MEAN_W'(in_units(my));
        r.mz = awmt_pkg::MEAN_W'(in_units(mz));
        r.roll = awmt_pkg::ROLL_W'(to_degrees(roll_ang));
        r.pitch = awmt_pkg::PITCH_W'(to_degrees(pitch_ang));
        tilt_queue.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_tilt_result got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                hist_x[i] = 0; hist_y[i] = 0; hist_z[i] = 0;
            end
            sum_x = 0; sum_y = 0; sum_z = 0;
            slot = 0;
            unit_sel = awmt_pkg::UNIT_RAW;
            tilt_queue.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) unit_sel = i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[61:0];
                if (tilt_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end else begin
                    want = tilt_queue.pop_front();
                    if (got !== want || m_axis_tdata[63:62] !== 2'b00) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("mismatch: exp mx=%0d my=%0d mz=%0d roll=%0d pitch=%0d",
                                     want.mx, want.my, want.mz, want.roll, want.pitch);
                            $display("          got mx=%0d my=%0d mz=%0d roll=%0d pitch=%0d",
                                     got.mx, got.my, got.mz, got.roll, got.pitch);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_tilt(s_axis_tdata);
            o_pending = tilt_queue.size();
        end
    end
endmodule

### tb/tb_accel_window_mean_tilt_core.sv
`timescale 1ns / 1ps

module tb_accel_window_mean_tilt_core;

    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_SAMPLES = 1300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          sink_wait;
    bit          hold_sink;
    bit          stim_done;

    accel_window_mean_tilt_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    tb_accel_window_mean_tilt_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The request stays up from one sample to the next when no gap is drawn.
    task automatic send_sample(logic signed [12:0] x, logic signed [12:0] y,
                               logic signed [12:0] z);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_units(logic [1:0] mode);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [12:0] rand_axis();
        case ($urandom_range(0, 3))
            0: return 13'($urandom);
            1: return 13'($signed($urandom_range(0, 600)) - 300);
            2: return $urandom_range(0, 1) ? 13'h0FFF : 13'h1000;
            default: return 13'($signed($urandom_range(0, 80)) - 40);
        endcase
    endfunction

    // Sink: a randomly drawn wait before each result is taken, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_sink) begin
            m_axis_tready <= 1'b0;
            sink_wait <= $urandom_range(0, 4);
        end else if (m_axis_tvalid && m_axis_tready) begin
            m_axis_tready <= 1'b0;
            sink_wait <= $urandom_range(0, 4);
        end else if (m_axis_tvalid && !m_axis_tready) begin
            if (sink_wait == 0)
                m_axis_tready <= 1'b1;
            else
                sink_wait <= sink_wait - 1;
        end
    end

    initial begin
        hold_sink = 1'b0;
        wait (stim_done === 1'b0);
        repeat (400) @(posedge i_clk);
        hold_sink <= 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_sink <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("accel_window_mean_tilt_core regression: fail");
            $finish;
        end
    end

    initial begin
        logic [12:0] ext[4];
        ext = '{13'h1000, 13'h0FFF, 13'h0000, 13'h1FFF};
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = awmt_pkg::UNIT_RAW;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vector, early window with reset zeros, extremes, each unit setting.
        send_sample(13'sd0, 13'sd0, 13'sd0);
        send_sample(13'sd256, 13'sd0, 13'sd0);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j += 3)
                send_sample(ext[i], ext[j], ext[(i + j) % 4]);
        for (int i = 0; i < 10; i++) send_sample(13'h1000, 13'h1000, 13'h1000);
        write_units(awmt_pkg::UNIT_MILLI_G);
        for (int i = 0; i < 10; i++) send_sample(13'h0FFF, 13'h0FFF, 13'h0FFF);
        write_units(awmt_pkg::UNIT_MPS2);
        send_sample(13'h1000, 13'h0FFF, 13'h0000);
        write_units(awmt_pkg::UNIT_SPARE);
        send_sample(13'sd0, -13'sd256, 13'sd256);

        // Random phases, each with a randomly drawn unit setting.
        for (int ph = 0; ph < 8; ph++) begin
            write_units(2'($urandom_range(0, 3)));
            for (int k = 0; k < RANDOM_SAMPLES / 8; k++)
                send_sample(rand_axis(), rand_axis(), rand_axis());
        end
        write_units(awmt_pkg::UNIT_RAW);
        for (int k = 0; k < 20; k++) send_sample(rand_axis(), rand_axis(), rand_axis());

        stim_done = 1'b1;
        drain_results();
        if (fail_count == 0)
            $display("accel_window_mean_tilt_core regression: pass");
        else
            $display("accel_window_mean_tilt_core regression: fail");
        $finish;
    end
endmodule
